[hdl/yuv2yc48_pkg.sv]
package yuv2yc48_pkg;

	localparam int unsigned LUMA_W = 14;
	localparam int unsigned CHR_W  = 13;
	localparam int unsigned MODE_W = 3;

	localparam logic [MODE_W-1:0] MODE_444_8  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_Y_8    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_444_16 = 3'd2;
	localparam logic [MODE_W-1:0] MODE_422_16 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_Y_16   = 3'd4;

	typedef logic signed [LUMA_W-1:0] luma_t;
	typedef logic signed [CHR_W-1:0]  chr_t;

	// converted samples of one input beat
	typedef struct packed {
		luma_t luma_a;
		luma_t luma_b;
		chr_t  cb;
		chr_t  cr;
	} pix_t;

	// one result beat
	typedef struct packed {
		luma_t luma;
		chr_t  cb;
		chr_t  cr;
		logic  line_last;
		logic  run_last;
	} res_t;

endpackage

[hdl/yuv2yc48_conv.sv]
module yuv2yc48_conv
	import yuv2yc48_pkg::*;
(
	input  logic [MODE_W-1:0] mode,
	input  logic [15:0]       luma_a,
	input  logic [15:0]       luma_b,
	input  logic [15:0]       cb_in,
	input  logic [15:0]       cr_in,
	output pix_t              pix
);

	function automatic luma_t luma8(input logic [7:0] y);
		logic [18:0] p;
		begin
			p = 19'(y) * 19'd1197;
			return $signed({1'b0, p[18:6]}) - 14'sd299;
		end
	endfunction

	function automatic chr_t chroma8(input logic [7:0] c);
		logic signed [8:0]  d;
		logic signed [22:0] p;
		begin
			d = $signed({1'b0, c}) - 9'sd128;
			p = 23'(d) * 23'sd4681 + 23'sd164;
			return p[20:8];
		end
	endfunction

	function automatic luma_t luma16(input logic [15:0] y);
		logic signed [16:0] d;
		logic signed [31:0] p;
		begin
			d = $signed({1'b0, y}) - 17'sd4096;
			p = 32'(d) * 32'sd4789;
			return p[29:16];
		end
	endfunction

	function automatic chr_t chroma16(input logic [15:0] c);
		logic signed [16:0] d;
		logic signed [31:0] p;
		begin
			d = $signed({1'b0, c}) - 17'sd32768;
			p = 32'(d) * 32'sd4683;
			return p[28:16];
		end
	endfunction

	always_comb begin
		pix.luma_b = luma16(luma_b);
		unique case (mode)
			MODE_444_8: begin
				pix.luma_a = luma8(luma_a[7:0]);
				pix.cb     = chroma8(cb_in[7:0]);
				pix.cr     = chroma8(cr_in[7:0]);
			end
			MODE_Y_8: begin
				pix.luma_a = luma8(luma_a[7:0]);
				pix.cb     = '0;
				pix.cr     = '0;
			end
			MODE_Y_16: begin
				pix.luma_a = luma16(luma_a);
				pix.cb     = '0;
				pix.cr     = '0;
			end
			default: begin
				pix.luma_a = luma16(luma_a);
				pix.cb     = chroma16(cb_in);
				pix.cr     = chroma16(cr_in);
			end
		endcase
	end

endmodule

[hdl/yuv_to_yc48_pixel_converter.sv]
// YUV to YC48 pixel converter.
// Input channel pix_valid/pix_ready carries one beat per pixel, or in 16-bit
// 4:2:2 mode one luma pair with one shared chroma pair. Output channel
// yc_valid/yc_ready gives one YC48 pixel per beat; run_last marks the last
// beat caused by an input beat, line_last the final pixel of a line.
// Config channel cfg_valid/cfg_ready writes the mode; write it only while idle.
// A mode write drops any pair held back in 4:2:2 mode.
// Data path: an accepted input beat waits in the input register, is converted
// and its result run is registered in the output stage, which offers it.
// Throughput: pixel modes take one beat per cycle while yc_ready is held high.
// A 4:2:2 pair yields two output beats; a line-end pair flushing a held pair
// yields four. A new run enters the output stage only as the last one ends.
// A 4:2:2 pair without line end is held until the next pair and emits nothing.
// Reset clears the mode to 8-bit 4:4:4 and drops all pending beats.
// When the receiver stalls, the result run waits in the output stage, one
// more input beat is taken into the input register, then pix_ready drops.
module yuv_to_yc48_pixel_converter
	import yuv2yc48_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  logic [15:0]       luma_a,
	input  logic [15:0]       luma_b,
	input  logic [15:0]       cb_in,
	input  logic [15:0]       cr_in,
	input  logic              line_end,
	output logic              yc_valid,
	input  logic              yc_ready,
	output luma_t             luma,
	output chr_t              cb_out,
	output chr_t              cr_out,
	output logic              line_last,
	output logic              run_last
);

	logic [MODE_W-1:0] mode_q;

	logic        valid_s1;
	logic [15:0] luma_a_s1;
	logic [15:0] luma_b_s1;
	logic [15:0] cb_s1;
	logic [15:0] cr_s1;
	logic        line_end_s1;

	logic        held_valid_q;
	luma_t       held_even_q;
	luma_t       held_odd_q;
	chr_t        held_cb_q;
	chr_t        held_cr_q;

	logic        valid_s2;
	res_t        run_s2 [4];
	logic [1:0]  last_idx_s2;
	logic [1:0]  rd_idx_q;

	pix_t        pix;
	res_t        run [4];
	logic [2:0]  run_len;
	logic [13:0] sum_cb;
	logic [13:0] sum_cr;
	chr_t        avg_cb;
	chr_t        avg_cr;
	logic        out_take;
	logic        out_done;
	logic        s2_free;
	logic        go_s1;
	res_t        cur;

	yuv2yc48_conv u_conv (
		.mode   (mode_q),
		.luma_a (luma_a_s1),
		.luma_b (luma_b_s1),
		.cb_in  (cb_s1),
		.cr_in  (cr_s1),
		.pix    (pix)
	);

	assign cfg_ready = 1'b1;

	assign out_take  = valid_s2 && yc_ready;
	assign out_done  = out_take && (rd_idx_q == last_idx_s2);
	assign s2_free   = !valid_s2 || out_done;
	assign go_s1     = valid_s1 && s2_free;
	assign pix_ready = !valid_s1 || go_s1;

	assign sum_cb = 14'(held_cb_q) + 14'(pix.cb);
	assign sum_cr = 14'(held_cr_q) + 14'(pix.cr);
	assign avg_cb = sum_cb[13:1];
	assign avg_cr = sum_cr[13:1];

	always_comb begin
		run[0]  = '{luma: pix.luma_a, cb: pix.cb, cr: pix.cr,
			line_last: line_end_s1, run_last: 1'b1};
		run[1]  = '0;
		run[2]  = '0;
		run[3]  = '0;
		run_len = 3'd0;
		unique case (mode_q)
			MODE_444_8, MODE_Y_8, MODE_444_16, MODE_Y_16: begin
				run_len = 3'd1;
			end
			MODE_422_16: begin
				if (held_valid_q) begin
					run[0] = '{luma: held_even_q, cb: held_cb_q, cr: held_cr_q,
						line_last: 1'b0, run_last: 1'b0};
					run[1] = '{luma: held_odd_q, cb: avg_cb, cr: avg_cr,
						line_last: 1'b0, run_last: !line_end_s1};
					run[2] = '{luma: pix.luma_a, cb: pix.cb, cr: pix.cr,
						line_last: 1'b0, run_last: 1'b0};
					run[3] = '{luma: pix.luma_b, cb: pix.cb, cr: pix.cr,
						line_last: 1'b1, run_last: 1'b1};
					run_len = line_end_s1 ? 3'd4 : 3'd2;
				end else begin
					run[0] = '{luma: pix.luma_a, cb: pix.cb, cr: pix.cr,
						line_last: 1'b0, run_last: 1'b0};
					run[1] = '{luma: pix.luma_b, cb: pix.cb, cr: pix.cr,
						line_last: 1'b1, run_last: 1'b1};
					run_len = line_end_s1 ? 3'd2 : 3'd0;
				end
			end
			default: begin
				run_len = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_444_8;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			luma_a_s1   <= luma_a;
			luma_b_s1   <= luma_b;
			cb_s1       <= cb_in;
			cr_s1       <= cr_in;
			line_end_s1 <= line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			held_valid_q <= 1'b0;
		end else if (go_s1 && mode_q == MODE_422_16) begin
			held_valid_q <= !line_end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && mode_q == MODE_422_16 && !line_end_s1) begin
			held_even_q <= pix.luma_a;
			held_odd_q  <= pix.luma_b;
			held_cb_q   <= pix.cb;
			held_cr_q   <= pix.cr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			last_idx_s2 <= 2'd0;
			rd_idx_q    <= 2'd0;
		end else if (go_s1 && run_len != 3'd0) begin
			valid_s2    <= 1'b1;
			last_idx_s2 <= 2'(run_len - 3'd1);
			rd_idx_q    <= 2'd0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
		end else if (out_take) begin
			rd_idx_q <= rd_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && run_len != 3'd0) begin
			run_s2 <= run;
		end
	end

	assign cur       = run_s2[rd_idx_q];
	assign yc_valid  = valid_s2;
	assign luma      = cur.luma;
	assign cb_out    = cur.cb;
	assign cr_out    = cur.cr;
	assign line_last = cur.line_last;
	assign run_last  = cur.run_last;

	a_rd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> rd_idx_q <= last_idx_s2)
		else $error("read index past end of run");

	a_run_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (run_last == (rd_idx_q == last_idx_s2)))
		else $error("run_last does not mark the final beat of a run");

	a_held_only_422: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> mode_q == MODE_422_16)
		else $error("pair held outside 4:2:2 mode");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !yc_ready) |=> $stable(rd_idx_q) && valid_s2)
		else $error("output run advanced while stalled");

endmodule
